/* hdl/sgig_pkg.sv */
// ----------------------------------------------------------------------------
// sgig_pkg
// shared constants and types for the strip grid index generator
// ----------------------------------------------------------------------------
package sgig_pkg;

    // default geometry limits
    localparam int DEF_MAX_COLUMNS = 255;
    localparam int DEF_MAX_ROWS    = 255;

    // fixed field widths
    localparam int IDX_W       = 19;
    localparam int CFG_W       = 8;
    localparam int PATCH_W     = 3;
    localparam int PATCH_COUNT = 8;

    // apb port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // register select (paddr bit 2)
    localparam logic REG_COLUMNS = 1'b0;
    localparam logic REG_ROWS    = 1'b1;

    localparam logic [CFG_W-1:0] CFG_RESET = 8'd1;

    // one result beat
    typedef struct packed {
        logic [IDX_W-1:0] vertex_index;
        logic             last_of_mesh;
    } sgig_result_t;

endpackage

/* hdl/sgig_apb_regs.sv */
// ----------------------------------------------------------------------------
// sgig_apb_regs
// apb register file for grid columns and rows, with clamped geometry outputs
// ----------------------------------------------------------------------------
module sgig_apb_regs #(
    parameter int MAX_COLUMNS = sgig_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = sgig_pkg::DEF_MAX_ROWS,
    localparam int COL_W = $clog2(MAX_COLUMNS + 1),
    localparam int W_W   = $clog2(MAX_COLUMNS + 2),
    localparam int ROW_W = $clog2(MAX_ROWS + 1)
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [sgig_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [sgig_pkg::APB_DATA_W-1:0] pwdata,
    output logic [sgig_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    output logic [W_W-1:0]                  row_width,
    output logic [ROW_W-1:0]                strip_count,
    output logic                            cfg_write
);

    logic [sgig_pkg::CFG_W-1:0] columns_reg;
    logic [sgig_pkg::CFG_W-1:0] rows_reg;
    logic [COL_W-1:0]           col_eff;
    logic [ROW_W-1:0]           row_eff;
    logic                       reg_sel;

    assign pready    = 1'b1;
    assign reg_sel   = paddr[2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            columns_reg <= sgig_pkg::CFG_RESET;
            rows_reg    <= sgig_pkg::CFG_RESET;
        end else if (cfg_write) begin
            unique case (reg_sel)
                sgig_pkg::REG_COLUMNS: columns_reg <= pwdata[sgig_pkg::CFG_W-1:0];
                sgig_pkg::REG_ROWS:    rows_reg    <= pwdata[sgig_pkg::CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_sel)
            sgig_pkg::REG_COLUMNS: prdata[sgig_pkg::CFG_W-1:0] = columns_reg;
            sgig_pkg::REG_ROWS:    prdata[sgig_pkg::CFG_W-1:0] = rows_reg;
            default:               prdata = '0;
        endcase
    end

    // zero acts as one, values above the limit saturate
    always_comb begin
        if (columns_reg == '0) begin
            col_eff = COL_W'(1);
        end else if (32'(columns_reg) > 32'(MAX_COLUMNS)) begin
            col_eff = COL_W'(MAX_COLUMNS);
        end else begin
            col_eff = COL_W'(columns_reg);
        end
    end

    always_comb begin
        if (rows_reg == '0) begin
            row_eff = ROW_W'(1);
        end else if (32'(rows_reg) > 32'(MAX_ROWS)) begin
            row_eff = ROW_W'(MAX_ROWS);
        end else begin
            row_eff = ROW_W'(rows_reg);
        end
    end

    assign row_width   = W_W'(col_eff) + W_W'(1);
    assign strip_count = row_eff;

endmodule

/* hdl/sgig_walker.sv */
// ----------------------------------------------------------------------------
// sgig_walker
// strip walk state and next index, one step per advance
// ----------------------------------------------------------------------------
module sgig_walker #(
    parameter int MAX_COLUMNS = sgig_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = sgig_pkg::DEF_MAX_ROWS,
    localparam int COL_W = $clog2(MAX_COLUMNS + 1),
    localparam int W_W   = $clog2(MAX_COLUMNS + 2),
    localparam int ROW_W = $clog2(MAX_ROWS + 1)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  clear_seq,
    input  logic                  advance,
    input  logic                  restart,
    input  logic [W_W-1:0]        row_width,
    input  logic [ROW_W-1:0]      strip_count,
    output sgig_pkg::sgig_result_t result
);

    localparam int IW = sgig_pkg::IDX_W;
    localparam int PW = sgig_pkg::PATCH_W;

    localparam logic [2:0] PH_TOP          = 3'd0;
    localparam logic [2:0] PH_BOTTOM       = 3'd1;
    localparam logic [2:0] PH_ROW_REPEAT   = 3'd2;
    localparam logic [2:0] PH_ROW_STITCH   = 3'd3;
    localparam logic [2:0] PH_PATCH_REPEAT = 3'd4;
    localparam logic [2:0] PH_PATCH_STITCH = 3'd5;

    logic [2:0]       phase_reg, phase_next, cur_phase;
    logic [PW-1:0]    patch_reg, patch_next, cur_patch;
    logic [ROW_W-1:0] row_reg, row_next, cur_row;
    logic [COL_W-1:0] col_reg, col_next, cur_col;
    logic [IW-1:0]    rbase_reg, rbase_next, cur_rbase;   // first vertex of current row
    logic [IW-1:0]    prev_reg, prev_next, cur_prev;
    logic             clr;
    logic             last;
    logic [IW-1:0]    idx;
    logic [IW-1:0]    w_ext;
    logic [IW-1:0]    col_ext;
    logic [W_W:0]     col_inc;
    logic [ROW_W:0]   row_inc;

    assign clr       = restart || (phase_reg > PH_PATCH_STITCH);
    assign cur_phase = clr ? PH_TOP : phase_reg;
    assign cur_patch = clr ? '0 : patch_reg;
    assign cur_row   = clr ? '0 : row_reg;
    assign cur_col   = clr ? '0 : col_reg;
    assign cur_rbase = clr ? '0 : rbase_reg;
    assign cur_prev  = clr ? '0 : prev_reg;

    assign w_ext   = IW'(row_width);
    assign col_ext = IW'(cur_col);
    assign col_inc = (W_W+1)'(cur_col) + (W_W+1)'(1);
    assign row_inc = (ROW_W+1)'(cur_row) + (ROW_W+1)'(1);

    always_comb begin
        phase_next = cur_phase;
        patch_next = cur_patch;
        row_next   = cur_row;
        col_next   = cur_col;
        rbase_next = cur_rbase;
        idx        = '0;
        last       = 1'b0;
        unique case (cur_phase)
            PH_TOP: begin
                idx        = cur_rbase + col_ext;
                phase_next = PH_BOTTOM;
            end
            PH_BOTTOM: begin
                idx = cur_rbase + w_ext + col_ext;
                if (col_inc < (W_W+1)'(row_width)) begin
                    col_next   = COL_W'(col_inc);
                    phase_next = PH_TOP;
                end else if (row_inc < (ROW_W+1)'(strip_count)) begin
                    phase_next = PH_ROW_REPEAT;
                end else if (cur_patch != PW'(sgig_pkg::PATCH_COUNT - 1)) begin
                    phase_next = PH_PATCH_REPEAT;
                end else begin
                    last = 1'b1;
                end
            end
            PH_ROW_REPEAT: begin
                idx        = cur_prev;
                phase_next = PH_ROW_STITCH;
            end
            PH_ROW_STITCH: begin
                idx        = cur_rbase + w_ext;
                rbase_next = idx;
                row_next   = ROW_W'(row_inc);
                col_next   = '0;
                phase_next = PH_TOP;
            end
            PH_PATCH_REPEAT: begin
                idx        = cur_prev;
                phase_next = PH_PATCH_STITCH;
            end
            PH_PATCH_STITCH: begin
                // last strip row plus two rows is the next patch base
                idx        = cur_rbase + w_ext + w_ext;
                rbase_next = idx;
                patch_next = cur_patch + PW'(1);
                row_next   = '0;
                col_next   = '0;
                phase_next = PH_TOP;
            end
            default: begin
                idx        = '0;
                phase_next = PH_TOP;
            end
        endcase
        prev_next = idx;
        if (last) begin
            phase_next = PH_TOP;
            patch_next = '0;
            row_next   = '0;
            col_next   = '0;
            rbase_next = '0;
            prev_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || clear_seq) begin
            phase_reg <= PH_TOP;
            patch_reg <= '0;
            row_reg   <= '0;
            col_reg   <= '0;
            rbase_reg <= '0;
            prev_reg  <= '0;
        end else if (advance) begin
            phase_reg <= phase_next;
            patch_reg <= patch_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            rbase_reg <= rbase_next;
            prev_reg  <= prev_next;
        end
    end

    assign result.vertex_index = idx;
    assign result.last_of_mesh = last;

    // end of mesh returns the walk to its start
    a_last_wraps: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && last && !clear_seq) |=>
            (phase_reg == PH_TOP && row_reg == '0 && col_reg == '0 && rbase_reg == '0))
        else $error("walk not back at start after last index");

    // column never runs past the row width
    a_col_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (W_W+1)'(col_reg) < (W_W+1)'(row_width))
        else $error("column position beyond row width");

    // a register write restarts the walk
    a_cfg_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        clear_seq |=> (phase_reg == PH_TOP && patch_reg == '0 && prev_reg == '0))
        else $error("walk state not cleared by register write");

endmodule

/* hdl/strip_grid_index_generator.sv */
// ----------------------------------------------------------------------------
// strip_grid_index_generator
// triangle strip index stream over eight grid patches with degenerate
// stitching between rows and between patches
// ----------------------------------------------------------------------------
//
//  port group | dir    | beat contents
//  -----------+--------+------------------------------------------------
//  s_*        | in     | restart (1 = start the sequence anew)
//  m_*        | out    | vertex_index (19 bit), last_of_mesh
//  apb        | in/out | grid_columns at 0x0, grid_rows at 0x4
//
//  one index per clock sustained while m_ready stays high; a taken beat
//  passes the input register, then the result register that drives m_valid
//  the walk itself is a single step of short logic on the walk state
//  while a result waits on m_ready one more beat fits in the input
//  register, after that s_ready stays low until m_ready returns
//  aresetn (synchronous) clears the walk and sets both registers to one
//  any register write also clears the walk
//
module strip_grid_index_generator #(
    parameter int MAX_COLUMNS = sgig_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = sgig_pkg::DEF_MAX_ROWS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input beats
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_restart,
    // result beats
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [sgig_pkg::IDX_W-1:0]      m_vertex_index,
    output logic                            m_last_of_mesh,
    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [sgig_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [sgig_pkg::APB_DATA_W-1:0] pwdata,
    output logic [sgig_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);

    localparam int W_W   = $clog2(MAX_COLUMNS + 2);
    localparam int ROW_W = $clog2(MAX_ROWS + 1);

    logic                  in_valid_reg;
    logic                  in_restart_reg;
    logic                  out_valid_reg;
    sgig_pkg::sgig_result_t out_result_reg;
    sgig_pkg::sgig_result_t step_result;
    logic                  advance;
    logic                  cfg_write;
    logic [W_W-1:0]        row_width;
    logic [ROW_W-1:0]      strip_count;

    // input stage moves on when the result register is free or draining
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    sgig_apb_regs #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_regs (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .row_width   (row_width),
        .strip_count (strip_count),
        .cfg_write   (cfg_write)
    );

    sgig_walker #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_walker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .clear_seq   (cfg_write),
        .advance     (advance),
        .restart     (in_restart_reg),
        .row_width   (row_width),
        .strip_count (strip_count),
        .result      (step_result)
    );

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_restart_reg <= s_restart;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_result_reg <= step_result;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_vertex_index = out_result_reg.vertex_index;
    assign m_last_of_mesh = out_result_reg.last_of_mesh;

    // a step always lands in the result register
    a_step_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("stepped beat lost before result register");

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |-> !advance)
        else $error("result register overwritten while stalled");

endmodule
